// ===== design/crs_pkg.sv =====
// Shared types and constants for the clip region rectangle splitter.
`timescale 1ns / 1ps

package crs_pkg;

  localparam int COORD_WIDTH_DEF = 16;

  // Piece slots in emission order, one bit each in the piece mask.
  localparam int NUM_PIECES = 5;
  localparam int PC_TOP     = 0;
  localparam int PC_LEFT    = 1;
  localparam int PC_MID     = 2;
  localparam int PC_RIGHT   = 3;
  localparam int PC_BOTTOM  = 4;

  localparam logic [NUM_PIECES-1:0] MASK_MID = NUM_PIECES'(1) << PC_MID;

  // Register map of the configuration port.
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;
  localparam logic [1:0] REG_CLIP_LEFT   = 2'd0;
  localparam logic [1:0] REG_CLIP_TOP    = 2'd1;
  localparam logic [1:0] REG_CLIP_RIGHT  = 2'd2;
  localparam logic [1:0] REG_CLIP_BOTTOM = 2'd3;

  // Per-item control: which pieces exist and whether the region passes through whole.
  typedef struct packed {
    logic                  pass;
    logic [NUM_PIECES-1:0] mask;
  } crs_ctrl_t;

endpackage

// ===== design/crs_split.sv =====
// Two-stage front end: clamps the region to the clip rectangle, then decides the pieces.
`timescale 1ns / 1ps

module crs_split #(
  parameter int COORD_WIDTH = crs_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_l,
  input  logic signed [COORD_WIDTH-1:0] in_t,
  input  logic signed [COORD_WIDTH-1:0] in_r,
  input  logic signed [COORD_WIDTH-1:0] in_b,
  input  logic signed [COORD_WIDTH-1:0] clip_l,
  input  logic signed [COORD_WIDTH-1:0] clip_t,
  input  logic signed [COORD_WIDTH-1:0] clip_r,
  input  logic signed [COORD_WIDTH-1:0] clip_b,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] a_l,
  output logic signed [COORD_WIDTH-1:0] a_t,
  output logic signed [COORD_WIDTH-1:0] a_r,
  output logic signed [COORD_WIDTH-1:0] a_b,
  output logic signed [COORD_WIDTH-1:0] b_l,
  output logic signed [COORD_WIDTH-1:0] b_t,
  output logic signed [COORD_WIDTH-1:0] b_r,
  output logic signed [COORD_WIDTH-1:0] b_b,
  output crs_pkg::crs_ctrl_t            ctrl
);
  import crs_pkg::*;

  logic                          v1;
  logic signed [COORD_WIDTH-1:0] s1_al, s1_at, s1_ar, s1_ab;
  logic signed [COORD_WIDTH-1:0] s1_bl, s1_bt, s1_br, s1_bb;
  logic                          s1_ready;
  logic                          s2_ready;
  crs_ctrl_t                     ctrl_next;

  assign s2_ready = !out_valid || out_ready;
  assign s1_ready = !v1 || s2_ready;
  assign in_ready = s1_ready;

  // Stage 1: overlap corners.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (s1_ready) begin
      v1 <= in_valid;
    end
    if (s1_ready && in_valid) begin
      s1_al <= in_l;
      s1_at <= in_t;
      s1_ar <= in_r;
      s1_ab <= in_b;
      s1_bl <= (in_l > clip_l) ? in_l : clip_l;
      s1_bt <= (in_t > clip_t) ? in_t : clip_t;
      s1_br <= (in_r < clip_r) ? in_r : clip_r;
      s1_bb <= (in_b < clip_b) ? in_b : clip_b;
    end
  end

  // Stage 2 decision: an empty overlap sends the region through as the middle piece.
  always_comb begin
    ctrl_next = '0;
    if (!(s1_bl < s1_br && s1_bt < s1_bb)) begin
      ctrl_next.pass = 1'b1;
      ctrl_next.mask = MASK_MID;
    end else begin
      ctrl_next.mask[PC_TOP]    = s1_at < s1_bt;
      ctrl_next.mask[PC_LEFT]   = s1_al < s1_bl;
      ctrl_next.mask[PC_MID]    = 1'b1;
      ctrl_next.mask[PC_RIGHT]  = s1_ar > s1_br;
      ctrl_next.mask[PC_BOTTOM] = s1_ab > s1_bb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= v1;
    end
    if (s2_ready && v1) begin
      a_l  <= s1_al;
      a_t  <= s1_at;
      a_r  <= s1_ar;
      a_b  <= s1_ab;
      b_l  <= s1_bl;
      b_t  <= s1_bt;
      b_r  <= s1_br;
      b_b  <= s1_bb;
      ctrl <= ctrl_next;
    end
  end

endmodule

// ===== design/clip_region_rect_split.sv =====
// Top level of the clip region rectangle splitter: register port, front end and piece emitter.
`timescale 1ns / 1ps
// An accepted request loads the overlap stage, then the decision stage and then the emitter, whose
// held registers drive the output. The emitter issues a single piece per cycle while the receiver
// takes them, and an item yields one to five pieces; the emitter loads the next item as it hands
// off the last piece of the current one.
// Reset (synchronous, active high) empties the pipeline and clears the clip rectangle to zero.

module clip_region_rect_split #(
  parameter int COORD_WIDTH = crs_pkg::COORD_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Configuration port.
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [crs_pkg::APB_ADDR_W-1:0]        paddr,
  input  logic [crs_pkg::APB_DATA_W-1:0]        pwdata,
  output logic [crs_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                  pready,
  // Region requests in.
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // region_left, region_top, region_right, region_bottom, then zero fill
  input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]    s_tdata,
  // Pieces out.
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // piece_left, piece_top, piece_right, piece_bottom, then zero fill
  output logic [((4*COORD_WIDTH+7)/8)*8-1:0]    m_tdata,
  // covered
  output logic                                  m_tuser,
  output logic                                  m_tlast
);
  import crs_pkg::*;

  localparam int W       = COORD_WIDTH;
  localparam int TDATA_W = ((4*COORD_WIDTH+7)/8)*8;

  // Clip rectangle registers.
  logic signed [W-1:0] clip_left, clip_top, clip_right, clip_bottom;
  logic                wr_en;
  logic [1:0]          reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_left   <= '0;
      clip_top    <= '0;
      clip_right  <= '0;
      clip_bottom <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_CLIP_LEFT:   clip_left   <= pwdata[W-1:0];
        REG_CLIP_TOP:    clip_top    <= pwdata[W-1:0];
        REG_CLIP_RIGHT:  clip_right  <= pwdata[W-1:0];
        REG_CLIP_BOTTOM: clip_bottom <= pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  // Reads return the stored value zero-extended to the bus width.
  always_comb begin
    case (reg_idx)
      REG_CLIP_LEFT:   prdata = APB_DATA_W'($unsigned(clip_left));
      REG_CLIP_TOP:    prdata = APB_DATA_W'($unsigned(clip_top));
      REG_CLIP_RIGHT:  prdata = APB_DATA_W'($unsigned(clip_right));
      REG_CLIP_BOTTOM: prdata = APB_DATA_W'($unsigned(clip_bottom));
      default:         prdata = '0;
    endcase
  end

  // Front end: overlap corners and the set of pieces, two register stages.
  logic                split_valid;
  logic                split_ready;
  logic signed [W-1:0] f_al, f_at, f_ar, f_ab, f_bl, f_bt, f_br, f_bb;
  crs_ctrl_t           f_ctrl;

  crs_split #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_split (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_l      (s_tdata[W-1:0]),
    .in_t      (s_tdata[2*W-1:W]),
    .in_r      (s_tdata[3*W-1:2*W]),
    .in_b      (s_tdata[4*W-1:3*W]),
    .clip_l    (clip_left),
    .clip_t    (clip_top),
    .clip_r    (clip_right),
    .clip_b    (clip_bottom),
    .out_valid (split_valid),
    .out_ready (split_ready),
    .a_l       (f_al),
    .a_t       (f_at),
    .a_r       (f_ar),
    .a_b       (f_ab),
    .b_l       (f_bl),
    .b_t       (f_bt),
    .b_r       (f_br),
    .b_b       (f_bb),
    .ctrl      (f_ctrl)
  );

  // Emitter: holds one item and walks its piece mask from the lowest set bit up.
  // The held registers act as the output register, so the front end can still fill
  // its two stages while a piece waits to be taken.
  logic signed [W-1:0]   e_al, e_at, e_ar, e_ab, e_bl, e_bt, e_br, e_bb;
  logic                  e_pass;
  logic [NUM_PIECES-1:0] e_mask;
  logic [NUM_PIECES-1:0] lowest;
  logic [NUM_PIECES-1:0] rest;
  logic                  out_fire;
  logic                  load;
  logic signed [W-1:0]   p_l, p_t, p_r, p_b;
  logic                  p_cov;

  assign lowest      = e_mask & (~e_mask + NUM_PIECES'(1));
  assign rest        = e_mask & ~lowest;
  assign m_tvalid    = |e_mask;
  assign m_tlast     = ~|rest;
  assign out_fire    = m_tvalid && m_tready;
  // Take the next item when empty or when the last piece of this one leaves.
  assign load        = !m_tvalid || (out_fire && m_tlast);
  assign split_ready = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_mask <= '0;
    end else if (load) begin
      e_mask <= split_valid ? f_ctrl.mask : '0;
    end else if (out_fire) begin
      e_mask <= rest;
    end
    if (load && split_valid) begin
      e_al   <= f_al;
      e_at   <= f_at;
      e_ar   <= f_ar;
      e_ab   <= f_ab;
      e_bl   <= f_bl;
      e_bt   <= f_bt;
      e_br   <= f_br;
      e_bb   <= f_bb;
      e_pass <= f_ctrl.pass;
    end
  end

  // Piece corners for the current slot.
  always_comb begin
    p_cov = 1'b0;
    case (lowest)
      NUM_PIECES'(1) << PC_TOP: begin
        p_l = e_al; p_t = e_at; p_r = e_ar; p_b = e_bt;
      end
      NUM_PIECES'(1) << PC_LEFT: begin
        p_l = e_al; p_t = e_bt; p_r = e_bl; p_b = e_bb;
      end
      NUM_PIECES'(1) << PC_MID: begin
        if (e_pass) begin
          p_l = e_al; p_t = e_at; p_r = e_ar; p_b = e_ab;
        end else begin
          p_l = e_bl; p_t = e_bt; p_r = e_br; p_b = e_bb;
          p_cov = 1'b1;
        end
      end
      NUM_PIECES'(1) << PC_RIGHT: begin
        p_l = e_br; p_t = e_bt; p_r = e_ar; p_b = e_bb;
      end
      NUM_PIECES'(1) << PC_BOTTOM: begin
        p_l = e_al; p_t = e_bb; p_r = e_ar; p_b = e_ab;
      end
      default: begin
        p_l = e_al; p_t = e_at; p_r = e_ar; p_b = e_ab;
      end
    endcase
  end

  assign m_tdata = TDATA_W'({p_b, p_r, p_t, p_l});
  assign m_tuser = p_cov;

  // A covered piece is always a nonempty overlap.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (p_l < p_r && p_t < p_b))
    else $error("covered piece is empty");

  // A pass-through item carries only the middle slot.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && e_pass) |-> (e_mask == MASK_MID))
    else $error("pass-through item has extra pieces");

  // After a piece that is not the last one leaves, the next piece follows at once.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
    else $error("item ended without its last piece");

  // At most one covered piece per item: the piece after a covered one is not covered.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tuser && !m_tlast) |=> !m_tuser)
    else $error("second covered piece in one item");

endmodule

// ===== verif/clip_split_checker.sv =====
// Piece checker for the clip region rectangle splitter: tracks the clip registers, predicts and compares.
`timescale 1ns / 1ps

module clip_split_checker #(
  parameter int COORD_W = 16,
  parameter int DATA_W  = ((4*COORD_W+7)/8)*8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [crs_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [crs_pkg::APB_DATA_W-1:0]  pwdata,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [DATA_W-1:0]               s_tdata,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [DATA_W-1:0]               m_tdata,
  input  logic                            m_tuser,
  input  logic                            m_tlast,
  output int                              fail_count,
  output int                              pending
);

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct {
    coord_t left;
    coord_t top;
    coord_t right;
    coord_t bottom;
    logic   covered;
    logic   last;
  } piece_t;

  coord_t clip_l, clip_t, clip_r, clip_b;
  piece_t pieces_due[$];

  function automatic coord_t smax(coord_t a, coord_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic coord_t smin(coord_t a, coord_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic coord_t coord_at(logic [DATA_W-1:0] d, int idx);
    return coord_t'(d[idx*COORD_W +: COORD_W]);
  endfunction

  function automatic string piece_str(piece_t p);
    return $sformatf("(%0d,%0d)-(%0d,%0d) covered=%0b last=%0b",
                     p.left, p.top, p.right, p.bottom, p.covered, p.last);
  endfunction

  function automatic void add_piece(coord_t l, coord_t t, coord_t r, coord_t b, logic cov);
    piece_t p;
    p.left    = l;
    p.top     = t;
    p.right   = r;
    p.bottom  = b;
    p.covered = cov;
    p.last    = 1'b0;
    pieces_due.push_back(p);
  endfunction

  // Splits one region against the clip rectangle on half-open bounds and queues the
  // pieces in emission order: top band, left strip, overlap, right strip, bottom band.
  function automatic void split_region(coord_t rl, coord_t rt, coord_t rr, coord_t rb);
    coord_t il, it, ir, ib;
    il = smax(rl, clip_l);
    it = smax(rt, clip_t);
    ir = smin(rr, clip_r);
    ib = smin(rb, clip_b);
    if (!(il < ir && it < ib)) begin
      add_piece(rl, rt, rr, rb, 1'b0);
    end else begin
      if (rt < it) add_piece(rl, rt, rr, it, 1'b0);
      if (rl < il) add_piece(rl, it, il, ib, 1'b0);
      add_piece(il, it, ir, ib, 1'b1);
      if (rr > ir) add_piece(ir, it, rr, ib, 1'b0);
      if (rb > ib) add_piece(rl, ib, rr, rb, 1'b0);
    end
    pieces_due[pieces_due.size()-1].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    piece_t got;
    piece_t want;
    if (rst) begin
      clip_l = '0;
      clip_t = '0;
      clip_r = '0;
      clip_b = '0;
      pieces_due.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (2'(paddr >> 2))
          crs_pkg::REG_CLIP_LEFT:   clip_l = coord_t'(pwdata[COORD_W-1:0]);
          crs_pkg::REG_CLIP_TOP:    clip_t = coord_t'(pwdata[COORD_W-1:0]);
          crs_pkg::REG_CLIP_RIGHT:  clip_r = coord_t'(pwdata[COORD_W-1:0]);
          crs_pkg::REG_CLIP_BOTTOM: clip_b = coord_t'(pwdata[COORD_W-1:0]);
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got.left    = coord_at(m_tdata, 0);
        got.top     = coord_at(m_tdata, 1);
        got.right   = coord_at(m_tdata, 2);
        got.bottom  = coord_at(m_tdata, 3);
        got.covered = m_tuser;
        got.last    = m_tlast;
        if (pieces_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: piece with nothing expected: %s", $realtime, piece_str(got));
        end else begin
          want = pieces_due.pop_front();
          if ({want.left, want.top, want.right, want.bottom, want.covered, want.last} !==
              {got.left, got.top, got.right, got.bottom, got.covered, got.last}) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: piece mismatch: expected %s, got %s",
                       $realtime, piece_str(want), piece_str(got));
          end
        end
      end
      if (s_tvalid && s_tready)
        split_region(coord_at(s_tdata, 0), coord_at(s_tdata, 1),
                     coord_at(s_tdata, 2), coord_at(s_tdata, 3));
    end
    pending = pieces_due.size();
  end

endmodule

// ===== verif/testbench.sv =====
// Top of the clip region rectangle splitter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
  import crs_pkg::*;

  localparam int COORD_W        = 16;
  localparam int DATA_W         = ((4*COORD_W+7)/8)*8;
  // Longest legal quiet spell is the receiver hold-off plus the pipeline fill, so a
  // limit well past that only trips on a real hang.
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 80;
  localparam int PHASE_ITEMS    = 72;

  typedef logic signed [COORD_W-1:0] coord_t;

  logic                   clk;
  logic                   rst;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [APB_ADDR_W-1:0]  paddr;
  logic [APB_DATA_W-1:0]  pwdata;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [DATA_W-1:0]      s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [DATA_W-1:0]      m_tdata;
  logic                   m_tuser;
  logic                   m_tlast;

  int fail_count;
  int pending;
  int idle_cycles;

  // Random idling on both sides is on unless a phase asks for a clean stretch.
  logic gaps_on  = 1'b1;
  // Set by the stimulus to make the receiver hold off; the receiver clears it when done.
  logic hold_req = 1'b0;

  // Local copy of the clip rectangle, only used to aim regions at its edges.
  coord_t cl, ct, cr, cb;

  clip_region_rect_split #(
    .COORD_WIDTH(COORD_W)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  clip_split_checker #(
    .COORD_W (COORD_W),
    .DATA_W  (DATA_W)
  ) piece_check (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver side. While gaps are on it stalls at random, 28 percent of the time, and when
  // asked it holds off for a long stretch so that the pipeline fills and the input backs up.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        m_tready = !gaps_on || ($urandom_range(0, 99) >= 28);
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves a request or a piece.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One register write: a setup phase, then an access phase held until pready.
  // Entered and left at a falling edge.
  task automatic write_reg(input logic [1:0] idx, input coord_t value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = APB_ADDR_W'(idx) << 2;
    pwdata  = APB_DATA_W'(value);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_clip(input coord_t l, input coord_t t, input coord_t r, input coord_t b);
    cl = l;
    ct = t;
    cr = r;
    cb = b;
    write_reg(REG_CLIP_LEFT, l);
    write_reg(REG_CLIP_TOP, t);
    write_reg(REG_CLIP_RIGHT, r);
    write_reg(REG_CLIP_BOTTOM, b);
  endtask

  // Drops valid and waits until every expected piece has come out. The clip registers
  // are only rewritten after this, while the block is idle.
  task automatic drain();
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Offers one region request and waits for it to be taken. Valid stays high on return,
  // so back-to-back requests keep it up without a glitch.
  task automatic send_region(input coord_t l, input coord_t t, input coord_t r, input coord_t b);
    while (gaps_on && $urandom_range(0, 99) < 28) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {b, r, t, l};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // A coordinate close to one of the two clip edges on an axis, or now and then anywhere or near zero.
  // Landing exactly on an edge exercises the half-open bounds.
  function automatic coord_t near_edge(coord_t lo, coord_t hi);
    coord_t d;
    d = coord_t'($urandom_range(1, 40));
    case ($urandom_range(0, 7))
      0: return lo - d;
      1: return lo;
      2: return lo + d;
      3: return hi - d;
      4: return hi;
      5: return hi + d;
      6: return coord_t'($urandom);
      default: return d - coord_t'(20);
    endcase
  endfunction

  // Most regions straddle the clip edges so that every mix of pieces shows up; the rest
  // are fully random, degenerate, or have their corners swapped.
  task automatic send_random_region();
    coord_t a, b, c, d, tmp;
    int kind;
    kind = $urandom_range(0, 99);
    a = near_edge(cl, cr);
    b = near_edge(cl, cr);
    c = near_edge(ct, cb);
    d = near_edge(ct, cb);
    if (kind < 65 || kind >= 95) begin
      if (kind < 65) begin
        if (a > b) begin
          tmp = a;
          a   = b;
          b   = tmp;
        end
        if (c > d) begin
          tmp = c;
          c   = d;
          d   = tmp;
        end
      end
    end else if (kind < 85) begin
      a = coord_t'($urandom);
      b = coord_t'($urandom);
      c = coord_t'($urandom);
      d = coord_t'($urandom);
    end else begin
      // Degenerate: zero or negative width or height.
      if ($urandom_range(0, 1)) begin
        b = a - coord_t'($urandom_range(0, 20));
      end else begin
        d = c - coord_t'($urandom_range(0, 20));
      end
    end
    send_region(a, c, b, d);
  endtask

  task automatic random_clip();
    coord_t l, t;
    l = coord_t'($urandom_range(0, 4000)) - coord_t'(2000);
    t = coord_t'($urandom_range(0, 4000)) - coord_t'(2000);
    set_clip(l, t, l + coord_t'($urandom_range(1, 600)), t + coord_t'($urandom_range(1, 600)));
  endtask

  initial begin
    rst      = 1'b1;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    cl       = '0;
    ct       = '0;
    cr       = '0;
    cb       = '0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Right after reset the clip rectangle is empty, so everything passes through.
    send_region(-5, -5, 5, 5);
    send_region(0, 0, 1, 1);
    send_region(-32768, -32768, 32767, 32767);
    drain();

    // Directed requests against a clip box centered on the origin.
    set_clip(-100, -50, 100, 50);
    send_region(-200, -100, 200, 100);       // all five pieces
    send_region(-10, -10, 10, 10);           // inside: overlap only
    send_region(-200, -10, 10, 10);          // left strip and overlap
    send_region(-10, -100, 10, 10);          // top band and overlap
    send_region(50, -10, 300, 10);           // overlap and right strip
    send_region(-10, 20, 10, 80);            // overlap and bottom band
    send_region(100, 0, 200, 10);            // starts at the exclusive right edge
    send_region(-300, 0, -100, 10);          // ends at the inclusive left edge
    send_region(-10, 50, 10, 60);            // starts at the exclusive bottom edge
    send_region(10, -10, -10, 10);           // degenerate: left above right
    send_region(0, 0, 0, 0);                 // degenerate: empty point
    send_region(-32768, -32768, 32767, 32767);
    send_region(32767, 32767, -32768, -32768);
    send_region(-32768, 0, 0, 32767);
    drain();

    // Clip box spanning the whole coordinate range.
    set_clip(-32768, -32768, 32767, 32767);
    send_region(-32768, -32768, 32767, 32767);
    send_region(-32768, 100, 32767, 32767);
    send_region(32767, 0, -32768, 5);
    drain();

    // Inverted clip box: no region can overlap it.
    set_clip(32767, 32767, -32768, -32768);
    send_region(-32768, -32768, 32767, 32767);
    send_region(-1, -1, 1, 1);

    // Random phases, each with its own clip setting.
    for (int phase = 0; phase < 6; phase++) begin
      drain();
      gaps_on = 1'b1;
      case (phase)
        2: begin
          gaps_on = 1'b0;
          random_clip();
        end
        3: begin
          random_clip();
          hold_req = 1'b1;
        end
        4: set_clip(-32768, -32768, -32468, -32468);
        5: begin
          cl = coord_t'($urandom);
          ct = coord_t'($urandom);
          if (cl == 32767) cl = 0;
          if (ct == 32767) ct = 0;
          set_clip(cl, ct, cl + coord_t'(1), ct + coord_t'(1));
        end
        default: random_clip();
      endcase
      repeat (PHASE_ITEMS) send_random_region();
    end

    drain();
    repeat (12) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
